[sv/assert_macros.svh]
// Assertion macros shared by the slot table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define FFSOT_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define FFSOT_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ffsot_pkg.sv]
// Shared types and constants for the first-free slot owner table.
`default_nettype none

package ffsot_pkg;

    localparam int OWNER_W = 16;
    localparam int COUNT_W = 9;
    localparam int FUNC_W  = 2;
    localparam int SEAT_W  = 9;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RESERVE = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_QUERY   = 2'd2
    } func_t;

    typedef struct packed {
        logic  valid;
        func_t func;
        logic  done;
        logic  err;
    } tok_ctl_t;

endpackage

`default_nettype wire

[sv/ffsot_cell.sv]
// One slot of the table: holds an owner and serves the request token passing by.
`default_nettype none

module ffsot_cell #(
    parameter int SLOT_W = 9
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  ffsot_pkg::tok_ctl_t        ctl_in,
    input  logic [ffsot_pkg::OWNER_W-1:0] pid_in,
    input  logic [SLOT_W-1:0]          slot_in,
    input  logic [SLOT_W-1:0]          tgt_in,
    input  logic [ffsot_pkg::OWNER_W-1:0] val_in,
    output ffsot_pkg::tok_ctl_t        ctl_out,
    output logic [ffsot_pkg::OWNER_W-1:0] pid_out,
    output logic [SLOT_W-1:0]          slot_out,
    output logic [SLOT_W-1:0]          tgt_out,
    output logic [ffsot_pkg::OWNER_W-1:0] val_out
);
    import ffsot_pkg::*;

    logic                occupied_reg;
    logic                occupied_next;
    logic [OWNER_W-1:0]  owner_reg;
    logic                owner_we;
    tok_ctl_t            ctl_reg;
    tok_ctl_t            ctl_next;
    logic [OWNER_W-1:0]  pid_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   tgt_reg;
    logic [OWNER_W-1:0]  val_reg;
    logic [OWNER_W-1:0]  val_next;
    logic                hit;

    assign hit = (tgt_in == slot_in);

    always_comb
    begin
        ctl_next      = ctl_in;
        val_next      = val_in;
        occupied_next = occupied_reg;
        owner_we      = 1'b0;
        if (ctl_in.valid && !ctl_in.done)
        begin
            case (ctl_in.func)
                FUNC_RESERVE:
                begin
                    if (!occupied_reg)
                    begin
                        occupied_next = 1'b1;
                        owner_we      = 1'b1;
                        ctl_next.done = 1'b1;
                        val_next      = OWNER_W'(slot_in);
                    end
                end
                FUNC_RELEASE:
                begin
                    if (hit)
                    begin
                        ctl_next.done = 1'b1;
                        if (occupied_reg)
                        begin
                            val_next      = owner_reg;
                            occupied_next = 1'b0;
                        end
                        else
                        begin
                            ctl_next.err = 1'b1;
                        end
                    end
                end
                FUNC_QUERY:
                begin
                    if (hit)
                    begin
                        ctl_next.done = 1'b1;
                        val_next      = occupied_reg ? owner_reg : '0;
                    end
                end
                default:
                begin
                    ctl_next.done = 1'b1;
                    ctl_next.err  = 1'b1;
                end
            endcase
        end
        if (clear)
        begin
            occupied_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= 1'b0;
            ctl_reg      <= '0;
        end
        else
        begin
            occupied_reg <= occupied_next;
            ctl_reg      <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (owner_we)
        begin
            owner_reg <= pid_in;
        end
        pid_reg  <= pid_in;
        slot_reg <= slot_in + SLOT_W'(1);
        tgt_reg  <= tgt_in;
        val_reg  <= val_next;
    end

    assign ctl_out  = ctl_reg;
    assign pid_out  = pid_reg;
    assign slot_out = slot_reg;
    assign tgt_out  = tgt_reg;
    assign val_out  = val_reg;

endmodule

`default_nettype wire

[sv/first_free_slot_owner_table.sv]
// Top level of the first-free slot owner table: entry check, cell row, counts.
// A request passes the entry register, the cell row and the result register, in that order.
// One request at a time: start is taken again in the result cycle, when busy falls.
// The request token walks the cell row one slot per cycle.
// Reset and every capacity write free all slots; reset leaves capacity 0.
// The result beat lasts one cycle; the receiver cannot stall it.
`default_nettype none
`include "assert_macros.svh"

module first_free_slot_owner_table #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ffsot_pkg::COUNT_W-1:0] cfg_wr_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [ffsot_pkg::FUNC_W-1:0]  func,
    input  logic [ffsot_pkg::OWNER_W-1:0] owner_id,
    input  logic [ffsot_pkg::SEAT_W-1:0]  seat_number,
    output logic                          done,
    output logic                          status,
    output logic [ffsot_pkg::OWNER_W-1:0] value,
    output logic [ffsot_pkg::COUNT_W-1:0] free_count,
    output logic [ffsot_pkg::COUNT_W-1:0] occupied_count
);
    import ffsot_pkg::*;

    localparam int SLOT_W = $clog2(MAX_SLOTS + 1);

    logic                accept;
    logic                seat_bad;
    logic                ent_err;
    logic [COUNT_W-1:0]  cap_sat;
    logic                res_err;

    tok_ctl_t            ent_ctl_reg;
    tok_ctl_t            ent_ctl_next;
    logic [OWNER_W-1:0]  ent_pid_reg;
    logic [SLOT_W-1:0]   ent_tgt_reg;

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic                status_reg;
    logic                status_next;
    logic [OWNER_W-1:0]  value_reg;
    logic [OWNER_W-1:0]  value_next;
    logic [COUNT_W-1:0]  cap_reg;
    logic [COUNT_W-1:0]  cap_next;
    logic [COUNT_W-1:0]  free_reg;
    logic [COUNT_W-1:0]  free_next;
    logic [COUNT_W-1:0]  used_reg;
    logic [COUNT_W-1:0]  used_next;

    tok_ctl_t            ctl_chain  [MAX_SLOTS+1];
    logic [OWNER_W-1:0]  pid_chain  [MAX_SLOTS+1];
    logic [SLOT_W-1:0]   slot_chain [MAX_SLOTS+1];
    logic [SLOT_W-1:0]   tgt_chain  [MAX_SLOTS+1];
    logic [OWNER_W-1:0]  val_chain  [MAX_SLOTS+1];

    assign accept  = start && !busy_reg;
    assign cap_sat = (32'(cfg_wr_data) > 32'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS) : cfg_wr_data;

    // Reject what the entry can judge; cells settle the rest.
    always_comb
    begin
        seat_bad = (seat_number == '0) || (seat_number > cap_reg);
        unique case (func) inside
            FUNC_RESERVE:             ent_err = (owner_id == '0) || (used_reg >= cap_reg);
            FUNC_RELEASE, FUNC_QUERY: ent_err = seat_bad;
            default:                  ent_err = 1'b1;
        endcase
        if (cap_reg == '0)
        begin
            ent_err = 1'b1;
        end
        ent_ctl_next.valid = accept;
        ent_ctl_next.func  = func_t'(func);
        ent_ctl_next.done  = ent_err;
        ent_ctl_next.err   = ent_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_ctl_reg <= '0;
        end
        else
        begin
            ent_ctl_reg <= ent_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_pid_reg <= owner_id;
        ent_tgt_reg <= SLOT_W'(seat_number);
    end

    assign ctl_chain[0]  = ent_ctl_reg;
    assign pid_chain[0]  = ent_pid_reg;
    assign slot_chain[0] = SLOT_W'(1);
    assign tgt_chain[0]  = ent_tgt_reg;
    assign val_chain[0]  = '0;

    for (genvar k = 0; k < MAX_SLOTS; k++)
    begin : g_cell
        ffsot_cell #(
            .SLOT_W (SLOT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (cfg_wr_en),
            .ctl_in   (ctl_chain[k]),
            .pid_in   (pid_chain[k]),
            .slot_in  (slot_chain[k]),
            .tgt_in   (tgt_chain[k]),
            .val_in   (val_chain[k]),
            .ctl_out  (ctl_chain[k+1]),
            .pid_out  (pid_chain[k+1]),
            .slot_out (slot_chain[k+1]),
            .tgt_out  (tgt_chain[k+1]),
            .val_out  (val_chain[k+1])
        );
    end

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        value_next  = value_reg;
        cap_next    = cap_reg;
        free_next   = free_reg;
        used_next   = used_reg;
        res_err     = ctl_chain[MAX_SLOTS].err || !ctl_chain[MAX_SLOTS].done;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (ctl_chain[MAX_SLOTS].valid)
        begin
            busy_next   = 1'b0;
            done_next   = 1'b1;
            status_next = res_err;
            value_next  = res_err ? '0 : val_chain[MAX_SLOTS];
            if (!res_err)
            begin
                case (ctl_chain[MAX_SLOTS].func)
                    FUNC_RESERVE:
                    begin
                        free_next = free_reg - COUNT_W'(1);
                        used_next = used_reg + COUNT_W'(1);
                    end
                    FUNC_RELEASE:
                    begin
                        free_next = free_reg + COUNT_W'(1);
                        used_next = used_reg - COUNT_W'(1);
                    end
                    default:
                    begin
                        free_next = free_reg;
                    end
                endcase
            end
        end
        if (cfg_wr_en)
        begin
            cap_next  = cap_sat;
            free_next = cap_sat;
            used_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cap_reg  <= '0;
            free_reg <= '0;
            used_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cap_reg  <= cap_next;
            free_reg <= free_next;
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign status         = status_reg;
    assign value          = value_reg;
    assign free_count     = free_reg;
    assign occupied_count = used_reg;

    `FFSOT_ASSERT_IMP(a_count_sum, clk, rst_n, done,
        10'(free_count) + 10'(occupied_count) == 10'(cap_reg),
        "free and occupied counts do not add up to capacity")
    `FFSOT_ASSERT_IMP(a_err_value, clk, rst_n, done && status, value == '0,
        "error beat carries a nonzero value")
    `FFSOT_ASSERT_IMP(a_no_table, clk, rst_n, done && (cap_reg == '0), status,
        "request succeeded with no table")
    `FFSOT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, busy && !done,
        "accepted request did not hold busy")

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the first-free slot owner table: queued requests, scoreboard.
`default_nettype none

module tb_top;
    import ffsot_pkg::*;

    localparam int MAX_SLOTS = 256;
    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int REPORT_LIMIT = 10;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [OWNER_W-1:0] owner_id;
        logic [SEAT_W-1:0]  seat_number;
    } request_t;

    typedef struct {
        logic               status;
        logic [OWNER_W-1:0] value;
        logic [COUNT_W-1:0] free_count;
        logic [COUNT_W-1:0] occupied_count;
    } answer_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0]  cfg_wr_data = '0;
    logic                start = 1'b0;
    logic                busy;
    logic [FUNC_W-1:0]   func = '0;
    logic [OWNER_W-1:0]  owner_id = '0;
    logic [SEAT_W-1:0]   seat_number = '0;
    logic                done;
    logic                status;
    logic [OWNER_W-1:0]  value;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  occupied_count;

    request_t request_q[$];
    answer_t  answer_q[$];

    logic [OWNER_W-1:0]  owner_tbl [0:MAX_SLOTS-1];
    int                  slots_in_use = 0;
    logic [COUNT_W-1:0]  free_ct = '0;
    logic [COUNT_W-1:0]  used_ct = '0;

    int mismatch_ct = 0;
    int cycle_ct = 0;
    int gap_left = 0;
    int burst_left = 1;

    first_free_slot_owner_table #(.MAX_SLOTS(MAX_SLOTS)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .owner_id       (owner_id),
        .seat_number    (seat_number),
        .done           (done),
        .status         (status),
        .value          (value),
        .free_count     (free_count),
        .occupied_count (occupied_count)
    );

    always #2 clk = ~clk;

    function automatic void clear_table(input logic [COUNT_W-1:0] cap_word);
        for (int i = 0; i < MAX_SLOTS; i++)
            owner_tbl[IDX_W'(i)] = '0;
        slots_in_use = (cap_word > MAX_SLOTS) ? MAX_SLOTS : int'(cap_word);
        free_ct = COUNT_W'(slots_in_use);
        used_ct = '0;
    endfunction

    function automatic void table_answer(input logic [FUNC_W-1:0] f,
                                         input logic [OWNER_W-1:0] pid,
                                         input logic [SEAT_W-1:0] seat);
        answer_t a;
        bit      found;
        a.status = 1'b1;
        a.value = '0;
        found = 1'b0;
        if (slots_in_use != 0) begin
            if (f == FUNC_RESERVE) begin
                if (pid != '0 && used_ct < slots_in_use) begin
                    for (int i = 0; i < slots_in_use && !found; i++) begin
                        if (owner_tbl[IDX_W'(i)] == '0) begin
                            owner_tbl[IDX_W'(i)] = pid;
                            free_ct = free_ct - 1'b1;
                            used_ct = used_ct + 1'b1;
                            a.value = OWNER_W'(i + 1);
                            a.status = 1'b0;
                            found = 1'b1;
                        end
                    end
                end
            end else if (f == FUNC_RELEASE) begin
                if (seat != '0 && seat <= slots_in_use &&
                    owner_tbl[IDX_W'(seat - 1'b1)] != '0) begin
                    a.value = owner_tbl[IDX_W'(seat - 1'b1)];
                    owner_tbl[IDX_W'(seat - 1'b1)] = '0;
                    free_ct = free_ct + 1'b1;
                    used_ct = used_ct - 1'b1;
                    a.status = 1'b0;
                end
            end else if (f == FUNC_QUERY) begin
                if (seat != '0 && seat <= slots_in_use) begin
                    a.value = owner_tbl[IDX_W'(seat - 1'b1)];
                    a.status = 1'b0;
                end
            end
        end
        a.free_count = free_ct;
        a.occupied_count = used_ct;
        answer_q.push_back(a);
    endfunction

    function automatic void note_mismatch(input string what);
        mismatch_ct++;
        if (mismatch_ct <= REPORT_LIMIT)
            $display("MISMATCH: %s", what);
    endfunction

    always @(posedge clk) begin : request_driver
        request_t nxt;
        if (rst_n) begin
            if (start && !busy)
                table_answer(func, owner_id, seat_number);
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end else if (request_q.size() > 0) begin
                    nxt = request_q.pop_front();
                    func <= nxt.func;
                    owner_id <= nxt.owner_id;
                    seat_number <= nxt.seat_number;
                    start <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 320)
                                                                : $urandom_range(0, 2);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : result_monitor
        answer_t a;
        if (rst_n && done) begin
            if (answer_q.size() == 0) begin
                note_mismatch($sformatf("unexpected beat status=%0d value=%0d free=%0d occ=%0d",
                                        status, value, free_count, occupied_count));
            end else begin
                a = answer_q.pop_front();
                if (status !== a.status || value !== a.value ||
                    free_count !== a.free_count || occupied_count !== a.occupied_count)
                    note_mismatch($sformatf(
                        "exp status=%0d value=%0d free=%0d occ=%0d, got %0d %0d %0d %0d",
                        a.status, a.value, a.free_count, a.occupied_count,
                        status, value, free_count, occupied_count));
            end
        end
    end

    always @(posedge clk) begin
        cycle_ct <= cycle_ct + 1;
        if (cycle_ct >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_req(input logic [FUNC_W-1:0] f, input logic [OWNER_W-1:0] pid,
                            input logic [SEAT_W-1:0] seat);
        request_t r;
        r.func = f;
        r.owner_id = pid;
        r.seat_number = seat;
        request_q.push_back(r);
    endtask

    task automatic settle();
        while (request_q.size() != 0 || start || answer_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [COUNT_W-1:0] cap_word);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cap_word;
        clear_table(cap_word);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(input logic [COUNT_W-1:0] cap_word, input int n_items,
                                input int reserve_pct);
        int span;
        int roll;
        logic [SEAT_W-1:0] seat;
        write_capacity(cap_word);
        span = (cap_word > MAX_SLOTS) ? MAX_SLOTS : int'(cap_word);
        for (int n = 0; n < n_items; n++) begin
            roll = $urandom_range(0, 99);
            seat = (span == 0) ? SEAT_W'($urandom_range(1, 511))
                               : SEAT_W'($urandom_range(1, span));
            if (roll < 6) begin
                case ($urandom_range(0, 3))
                    0: push_req(FUNC_RESERVE, '0, SEAT_W'($urandom));
                    1: push_req(FUNC_SPARE, OWNER_W'($urandom), SEAT_W'($urandom));
                    2: push_req($urandom_range(0, 1) ? FUNC_RELEASE : FUNC_QUERY,
                                OWNER_W'($urandom), '0);
                    default: push_req($urandom_range(0, 1) ? FUNC_RELEASE : FUNC_QUERY,
                                      OWNER_W'($urandom), SEAT_W'($urandom));
                endcase
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < reserve_pct)
                    push_req(FUNC_RESERVE, OWNER_W'($urandom_range(1, 65535)),
                             SEAT_W'($urandom));
                else if (roll < reserve_pct + (100 - reserve_pct) * 2 / 3)
                    push_req(FUNC_RELEASE, OWNER_W'($urandom), seat);
                else
                    push_req(FUNC_QUERY, OWNER_W'($urandom), seat);
            end
        end
    endtask

    initial begin
        clear_table('0);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_req(FUNC_RESERVE, 16'h1234, 9'd0);
        push_req(FUNC_QUERY, 16'h0000, 9'd1);
        push_req(FUNC_RELEASE, 16'h0000, 9'd1);
        push_req(FUNC_SPARE, 16'h0000, 9'd0);

        write_capacity(9'd2);
        push_req(FUNC_RESERVE, 16'hFFFF, 9'd0);
        push_req(FUNC_RESERVE, 16'h0000, 9'd0);
        push_req(FUNC_RESERVE, 16'h0001, 9'd0);
        push_req(FUNC_RESERVE, 16'h00AA, 9'd0);
        push_req(FUNC_QUERY, 16'h0000, 9'd0);
        push_req(FUNC_QUERY, 16'h0000, 9'd3);
        push_req(FUNC_QUERY, 16'hFFFF, 9'd511);
        push_req(FUNC_QUERY, 16'h0000, 9'd2);
        push_req(FUNC_RELEASE, 16'h0000, 9'd0);
        push_req(FUNC_RELEASE, 16'h0000, 9'd3);
        push_req(FUNC_RELEASE, 16'h0000, 9'd1);
        push_req(FUNC_RELEASE, 16'h0000, 9'd1);
        push_req(FUNC_QUERY, 16'h0000, 9'd1);
        push_req(FUNC_RESERVE, 16'h5555, 9'd0);
        push_req(FUNC_SPARE, 16'hFFFF, 9'd1);

        write_capacity(9'd511);
        push_req(FUNC_QUERY, 16'h0000, 9'd256);
        push_req(FUNC_QUERY, 16'h0000, 9'd257);
        push_req(FUNC_RESERVE, 16'hAAAA, 9'd0);

        random_phase(9'd1, 60, 50);
        random_phase(9'd256, 380, 85);
        random_phase(9'd3, 120, 45);
        random_phase(9'd0, 30, 40);
        random_phase(9'd300, 300, 70);
        random_phase(COUNT_W'($urandom_range(4, 40)), 250, 50);
        random_phase(9'd2, 100, 45);
        random_phase(9'd511, 150, 55);
        random_phase(COUNT_W'($urandom_range(41, 255)), 120, 60);

        while (request_q.size() != 0 || start || answer_q.size() != 0)
            @(posedge clk);
        repeat (MAX_SLOTS + 16) @(posedge clk);
        if (answer_q.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", answer_q.size()));

        if (mismatch_ct == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+sv
sv/ffsot_pkg.sv
sv/ffsot_cell.sv
sv/first_free_slot_owner_table.sv
bench/tb_top.sv
